// ===== sv/soos_pkg.sv =====
// ----------------------------------------------------------------------------
// Sound onset/offset segmenter package
// Shared types, register indexes and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package soos_pkg;

   localparam int INDEX_BITS_DEFAULT = 32;

   localparam int SAMPLE_BITS   = 16;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int RSP_DATA_BITS = 144;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HOLD_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ATTACK_GAP      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUIET_LIMIT     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SHORTEST_SOUND  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEGMENT_SIZE    = 3'd5;

   // Register reset values.
   localparam logic [CSR_DATA_BITS-1:0] RST_START_THRESHOLD = 16'd16384;
   localparam logic [CSR_DATA_BITS-1:0] RST_HOLD_THRESHOLD  = 16'd1024;
   localparam logic [CSR_DATA_BITS-1:0] RST_ATTACK_GAP      = 16'd2048;
   localparam logic [CSR_DATA_BITS-1:0] RST_QUIET_LIMIT     = 16'd2048;
   localparam logic [CSR_DATA_BITS-1:0] RST_SHORTEST_SOUND  = 16'd1024;
   localparam logic [CSR_DATA_BITS-1:0] RST_SEGMENT_SIZE    = 16'd1024;

   typedef struct packed {
      logic [CSR_DATA_BITS-1:0] start_threshold;
      logic [CSR_DATA_BITS-1:0] hold_threshold;
      logic [CSR_DATA_BITS-1:0] attack_gap;
      logic [CSR_DATA_BITS-1:0] quiet_limit;
      logic [CSR_DATA_BITS-1:0] shortest_sound;
      logic [CSR_DATA_BITS-1:0] segment_size;
   } soos_cfg_type;

   typedef struct packed {
      logic        final_of_run;
      logic [15:0] sound_number;
      logic [31:0] end_segment;
      logic [31:0] begin_segment;
      logic [31:0] end_index;
      logic [31:0] begin_index;
   } soos_result_type;

   // One queue entry carries all results caused by one sample.
   typedef struct packed {
      logic            has_second;
      soos_result_type second;
      soos_result_type first;
   } soos_entry_type;

endpackage

`default_nettype wire

// ===== sv/soos_front.sv =====
// ----------------------------------------------------------------------------
// Segmenter front end
// Accepts samples, tracks sound state and packs the results of each sample.
// ----------------------------------------------------------------------------
`default_nettype none

module soos_front #(
   parameter int INDEX_BITS = soos_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire soos_pkg::soos_cfg_type              cfg,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [soos_pkg::SAMPLE_BITS-1:0]    sample,
   input  wire logic                                last,
   input  wire logic                                queue_full,
   output logic                                     push,
   output soos_pkg::soos_entry_type                 entry
);

   localparam logic [INDEX_BITS-1:0] IdxMax   = '1;
   localparam logic [16:0]           QuietMax = '1;

   logic [INDEX_BITS-1:0] sample_index_ff,   sample_index_in;
   logic [15:0]           segment_offset_ff, segment_offset_in;
   logic [INDEX_BITS-1:0] segment_number_ff, segment_number_in;
   logic [INDEX_BITS-1:0] start_index_ff,    start_index_in;
   logic [INDEX_BITS-1:0] start_segment_ff,  start_segment_in;
   logic [16:0]           quiet_count_ff,    quiet_count_in;
   logic                  audible_ff,        audible_in;
   logic                  sound_open_ff,     sound_open_in;
   logic [15:0]           emitted_count_ff,  emitted_count_in;

   logic                  accept;
   logic [16:0]           mag;
   logic [16:0]           seg_size;
   logic                  active;
   logic [INDEX_BITS-1:0] since_start;
   logic                  start_hit;
   logic                  keep_on;
   logic                  quiet_path;
   logic [16:0]           quiet_inc;
   logic                  quiet_expire;
   logic                  long_old;
   logic                  emit_a;
   logic                  emit_b;
   logic                  audible_after;
   logic                  open_b;
   logic                  long_b;
   logic [15:0]           emitted_inc;
   soos_pkg::soos_result_type res_a;
   soos_pkg::soos_result_type res_b;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && !queue_full;

   // The most negative sample has magnitude 32768; the magnitude is 17 bits wide.
   assign mag = sample[soos_pkg::SAMPLE_BITS-1]
              ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
   assign seg_size = (cfg.segment_size == '0) ? 17'd1 : {1'b0, cfg.segment_size};

   assign active      = (segment_number_ff != '0);
   assign since_start = sample_index_ff - start_index_ff;
   assign start_hit   = active && (mag >= {1'b0, cfg.start_threshold})
                     && (since_start > INDEX_BITS'(cfg.attack_gap));
   assign keep_on     = audible_ff && (mag >= {1'b0, cfg.hold_threshold});
   assign quiet_path  = active && !start_hit && audible_ff && !keep_on;
   assign quiet_inc   = (quiet_count_ff == QuietMax) ? quiet_count_ff
                                                     : quiet_count_ff + 17'd1;
   assign quiet_expire = quiet_path && (quiet_inc > {1'b0, cfg.quiet_limit});

   assign long_old = (since_start >= INDEX_BITS'(cfg.shortest_sound));
   assign emit_a   = (start_hit || quiet_expire) && sound_open_ff && long_old;

   assign audible_after = start_hit ? 1'b1 : (quiet_expire ? 1'b0 : audible_ff);

   // A sound started on this sample has length zero if the last sample closes it.
   assign open_b = start_hit || (sound_open_ff && !emit_a);
   assign long_b = start_hit ? (cfg.shortest_sound == '0) : long_old;
   assign emit_b = last && audible_after && open_b && long_b;

   assign emitted_inc = (emitted_count_ff == 16'hFFFF) ? emitted_count_ff
                                                       : emitted_count_ff + 16'd1;

   always_comb begin
      res_a.begin_index   = 32'(start_index_ff);
      res_a.end_index     = 32'(sample_index_ff);
      res_a.begin_segment = 32'(start_segment_ff);
      res_a.end_segment   = 32'(segment_number_ff);
      res_a.sound_number  = emitted_count_ff;
      res_a.final_of_run  = !emit_b;

      res_b.begin_index   = start_hit ? 32'(sample_index_ff) : 32'(start_index_ff);
      res_b.end_index     = 32'(sample_index_ff);
      res_b.begin_segment = start_hit ? 32'(segment_number_ff) : 32'(start_segment_ff);
      res_b.end_segment   = 32'(segment_number_ff);
      res_b.sound_number  = emit_a ? emitted_inc : emitted_count_ff;
      res_b.final_of_run  = 1'b1;

      entry.first      = emit_a ? res_a : res_b;
      entry.second     = res_b;
      entry.has_second = emit_a && emit_b;
   end

   assign push = accept && (emit_a || emit_b);

   always_comb begin
      sample_index_in   = sample_index_ff;
      segment_offset_in = segment_offset_ff;
      segment_number_in = segment_number_ff;
      start_index_in    = start_index_ff;
      start_segment_in  = start_segment_ff;
      quiet_count_in    = quiet_count_ff;
      audible_in        = audible_ff;
      sound_open_in     = sound_open_ff;
      emitted_count_in  = emitted_count_ff;
      if (accept) begin
         if (last) begin
            // The next sample opens a new recording.
            sample_index_in   = '0;
            segment_offset_in = '0;
            segment_number_in = '0;
            start_index_in    = '0;
            start_segment_in  = '0;
            quiet_count_in    = '0;
            audible_in        = 1'b0;
            sound_open_in     = 1'b0;
            emitted_count_in  = '0;
         end else begin
            audible_in    = audible_after;
            sound_open_in = open_b;
            if (emit_a) begin
               emitted_count_in = emitted_inc;
            end
            if (start_hit) begin
               start_index_in   = sample_index_ff;
               start_segment_in = segment_number_ff;
               quiet_count_in   = '0;
            end else if (active && keep_on) begin
               quiet_count_in = '0;
            end else if (quiet_path) begin
               quiet_count_in = quiet_inc;
            end
            if (sample_index_ff != IdxMax) begin
               sample_index_in = sample_index_ff + 1'b1;
               if (({1'b0, segment_offset_ff} + 17'd1) >= seg_size) begin
                  segment_offset_in = '0;
                  if (segment_number_ff != IdxMax) begin
                     segment_number_in = segment_number_ff + 1'b1;
                  end
               end else begin
                  segment_offset_in = segment_offset_ff + 16'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff   <= '0;
         segment_offset_ff <= '0;
         segment_number_ff <= '0;
         start_index_ff    <= '0;
         start_segment_ff  <= '0;
         quiet_count_ff    <= '0;
         audible_ff        <= 1'b0;
         sound_open_ff     <= 1'b0;
         emitted_count_ff  <= '0;
      end else begin
         sample_index_ff   <= sample_index_in;
         segment_offset_ff <= segment_offset_in;
         segment_number_ff <= segment_number_in;
         start_index_ff    <= start_index_in;
         start_segment_ff  <= start_segment_in;
         quiet_count_ff    <= quiet_count_in;
         audible_ff        <= audible_in;
         sound_open_ff     <= sound_open_in;
         emitted_count_ff  <= emitted_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/soos_queue.sv =====
// ----------------------------------------------------------------------------
// Segmenter result queue
// Short FIFO of result entries between the front end and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module soos_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   input  wire soos_pkg::soos_entry_type push_entry,
   output logic                          full,
   output logic                          valid,
   output soos_pkg::soos_entry_type      head,
   input  wire logic                     pop
);

   localparam int PtrBits = soos_pkg::QUEUE_PTR_BITS;

   soos_pkg::soos_entry_type slots_ff [soos_pkg::QUEUE_DEPTH];
   logic [PtrBits-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PtrBits:0]   count_ff,  count_in;
   logic               do_push;
   logic               do_pop;

   assign full  = (count_ff == (PtrBits+1)'(soos_pkg::QUEUE_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slots_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/soos_back.sv =====
// ----------------------------------------------------------------------------
// Segmenter output stage
// Unpacks queue entries into single results on a registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module soos_back (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               q_valid,
   input  wire soos_pkg::soos_entry_type           q_head,
   output logic                                    q_pop,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [soos_pkg::RSP_DATA_BITS-1:0]      rsp_tdata,
   output logic                                    rsp_tlast
);

   soos_pkg::soos_result_type out_ff,   out_in;
   soos_pkg::soos_result_type pend_ff,  pend_in;
   logic                      out_valid_ff,  out_valid_in;
   logic                      pend_valid_ff, pend_valid_in;
   logic                      can_load;

   assign can_load = !out_valid_ff || rsp_tready;

   always_comb begin
      out_in        = out_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      pend_valid_in = pend_valid_ff;
      q_pop         = 1'b0;
      if (can_load) begin
         if (pend_valid_ff) begin
            out_in        = pend_ff;
            out_valid_in  = 1'b1;
            pend_valid_in = 1'b0;
         end else if (q_valid) begin
            // The second result of an entry waits in the pending register.
            q_pop         = 1'b1;
            out_in        = q_head.first;
            out_valid_in  = 1'b1;
            pend_in       = q_head.second;
            pend_valid_in = q_head.has_second;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ff.sound_number, out_ff.end_segment, out_ff.begin_segment,
                        out_ff.end_index, out_ff.begin_index};
   assign rsp_tlast  = out_ff.final_of_run;

endmodule

`default_nettype wire

// ===== sv/sound_onset_offset_segmenter.sv =====
// ----------------------------------------------------------------------------
// Sound onset/offset segmenter
// Finds sounds in a sample stream by magnitude thresholds and reports them.
// ----------------------------------------------------------------------------
// Samples enter on the req_ channel, one per cycle at full rate; req_tlast
// marks the final sample of a recording and returns all tracking state to its
// reset value afterwards. Each sample causes zero, one or two results on the
// rsp_ channel; rsp_tlast marks the last result caused by one sample.
// The front end decides per sample combinationally and writes the results of
// that sample as one entry into a four-entry queue. The output stage takes one
// entry and presents its results one per cycle from an output register while
// the receiver is ready; a result passes through the queue and the output
// register. A sample that closes two sounds holds the output for both results.
// When the receiver stalls, results collect in the output stage and the queue,
// and req_tready drops only once all four queue entries are taken; until then
// every sample is accepted at full rate.
// Reset is synchronous; it clears the tracking state, empties the queue and
// loads the registers with their default values. Registers are written through
// csr_we/csr_index/csr_wdata; the user must write them only while the block is
// idle, which the block does not enforce; indexes past the list are ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module sound_onset_offset_segmenter #(
   parameter int INDEX_BITS = soos_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // req_tdata fields from bit 0: sample[15:0]
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [soos_pkg::SAMPLE_BITS-1:0]      req_tdata,
   input  wire logic                                  req_tlast,
   // rsp_tdata fields from bit 0: begin_index[31:0], end_index[31:0],
   // begin_segment[31:0], end_segment[31:0], sound_number[15:0]
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [soos_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   output logic                                       rsp_tlast,
   input  wire logic                                  csr_we,
   input  wire logic [soos_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [soos_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   soos_pkg::soos_cfg_type   cfg_ff, cfg_in;
   soos_pkg::soos_entry_type entry;
   soos_pkg::soos_entry_type q_head;
   logic                     push;
   logic                     queue_full;
   logic                     q_valid;
   logic                     q_pop;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            soos_pkg::CSR_START_THRESHOLD: cfg_in.start_threshold = csr_wdata;
            soos_pkg::CSR_HOLD_THRESHOLD:  cfg_in.hold_threshold  = csr_wdata;
            soos_pkg::CSR_ATTACK_GAP:      cfg_in.attack_gap      = csr_wdata;
            soos_pkg::CSR_QUIET_LIMIT:     cfg_in.quiet_limit     = csr_wdata;
            soos_pkg::CSR_SHORTEST_SOUND:  cfg_in.shortest_sound  = csr_wdata;
            soos_pkg::CSR_SEGMENT_SIZE:    cfg_in.segment_size    = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_threshold <= soos_pkg::RST_START_THRESHOLD;
         cfg_ff.hold_threshold  <= soos_pkg::RST_HOLD_THRESHOLD;
         cfg_ff.attack_gap      <= soos_pkg::RST_ATTACK_GAP;
         cfg_ff.quiet_limit     <= soos_pkg::RST_QUIET_LIMIT;
         cfg_ff.shortest_sound  <= soos_pkg::RST_SHORTEST_SOUND;
         cfg_ff.segment_size    <= soos_pkg::RST_SEGMENT_SIZE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   soos_front #(
      .INDEX_BITS (INDEX_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sample     (req_tdata),
      .last       (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .entry      (entry)
   );

   soos_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (entry),
      .full       (queue_full),
      .valid      (q_valid),
      .head       (q_head),
      .pop        (q_pop)
   );

   soos_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== bench/segmenter_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound segmenter checker
// Watches the sample, result and register ports of the segmenter. Every
// accepted sample runs through a cycle-free model of the sound tracker, and
// the sounds it closes are queued. Each accepted result is compared field by
// field with the oldest queued sound.
// ----------------------------------------------------------------------------

module segmenter_checker (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic                                  req_tready,
   input  wire logic [soos_pkg::SAMPLE_BITS-1:0]      req_tdata,
   input  wire logic                                  req_tlast,
   input  wire logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic [soos_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  wire logic                                  rsp_tlast,
   input  wire logic                                  csr_we,
   input  wire logic [soos_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [soos_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                         mismatch_count,
   output int                                         pending_sounds
);

   localparam int INDEX_BITS = soos_pkg::INDEX_BITS_DEFAULT;
   localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
   localparam logic [16:0] QUIET_MAX = '1;
   localparam int REPORT_LIMIT = 10;

   soos_pkg::soos_cfg_type cfg;

   logic [INDEX_BITS-1:0] sample_index;
   logic [INDEX_BITS-1:0] segment_number;
   logic [INDEX_BITS-1:0] sound_begin;
   logic [INDEX_BITS-1:0] sound_begin_segment;
   logic [15:0]           segment_offset;
   logic [16:0]           quiet_count;
   logic [15:0]           emitted_count;
   logic                  audible;
   logic                  sound_open;

   soos_pkg::soos_result_type expected_sounds[$];
   soos_pkg::soos_result_type closed_now[$];
   int mismatches = 0;

   function automatic string describe(input soos_pkg::soos_result_type r);
      return $sformatf("begin %0d seg %0d, end %0d seg %0d, sound %0d, last %0b",
                       r.begin_index, r.begin_segment, r.end_index, r.end_segment,
                       r.sound_number, r.final_of_run);
   endfunction

   task automatic flag_mismatch(input string what, input string want, input string seen);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
         $display("%0t: %s: expected %s; got %s", $time, what, want, seen);
      end
   endtask

   task automatic clear_tracking();
      sample_index = '0;
      segment_offset = '0;
      segment_number = '0;
      sound_begin = '0;
      sound_begin_segment = '0;
      quiet_count = '0;
      audible = 1'b0;
      sound_open = 1'b0;
      emitted_count = '0;
   endtask

   // A closed sound that is too short stays open and can still be emitted later.
   task automatic close_sound(input logic [INDEX_BITS-1:0] end_idx,
                              input logic [INDEX_BITS-1:0] end_seg);
      soos_pkg::soos_result_type r;
      if (sound_open && closed_now.size() < 2 &&
          (end_idx - sound_begin) >= INDEX_BITS'(cfg.shortest_sound)) begin
         r.begin_index   = sound_begin;
         r.end_index     = end_idx;
         r.begin_segment = sound_begin_segment;
         r.end_segment   = end_seg;
         r.sound_number  = emitted_count;
         r.final_of_run  = 1'b0;
         closed_now.insert(closed_now.size(), r);
         if (emitted_count != 16'hFFFF) begin
            emitted_count++;
         end
         sound_open = 1'b0;
      end
   endtask

   task automatic segment_sample(input logic [15:0] sample, input logic last);
      logic [16:0]           magnitude;
      logic [16:0]           seg_len;
      logic [INDEX_BITS-1:0] idx;
      logic [INDEX_BITS-1:0] seg;
      soos_pkg::soos_result_type r;
      magnitude = sample[15] ? (17'h10000 - {1'b0, sample}) : {1'b0, sample};
      idx = sample_index;
      seg = segment_number;
      seg_len = (cfg.segment_size == '0) ? 17'd1 : {1'b0, cfg.segment_size};
      closed_now.delete();

      // Nothing but counting happens during the lead-in segment.
      if (seg != '0) begin
         if (magnitude >= {1'b0, cfg.start_threshold} &&
             (idx - sound_begin) > INDEX_BITS'(cfg.attack_gap)) begin
            close_sound(idx, seg);
            quiet_count = '0;
            audible = 1'b1;
            sound_open = 1'b1;
            sound_begin = idx;
            sound_begin_segment = seg;
         end else if (audible && magnitude >= {1'b0, cfg.hold_threshold}) begin
            quiet_count = '0;
         end else if (audible) begin
            if (quiet_count != QUIET_MAX) begin
               quiet_count++;
            end
            if (quiet_count > {1'b0, cfg.quiet_limit}) begin
               audible = 1'b0;
               close_sound(idx, seg);
            end
         end
      end
      if (last && audible) begin
         close_sound(idx, seg);
      end

      if (closed_now.size() != 0) begin
         r = closed_now[closed_now.size() - 1];
         r.final_of_run = 1'b1;
         closed_now[closed_now.size() - 1] = r;
      end
      foreach (closed_now[k]) begin
         expected_sounds.insert(expected_sounds.size(), closed_now[k]);
      end

      if (last) begin
         clear_tracking();
      end else if (sample_index != INDEX_MAX) begin
         sample_index++;
         if ({1'b0, segment_offset} + 17'd1 >= seg_len) begin
            segment_offset = '0;
            if (segment_number != INDEX_MAX) begin
               segment_number++;
            end
         end else begin
            segment_offset++;
         end
      end
   endtask

   always @(posedge clock) begin : watch
      soos_pkg::soos_result_type seen;
      soos_pkg::soos_result_type want;
      if (reset) begin
         cfg.start_threshold = soos_pkg::RST_START_THRESHOLD;
         cfg.hold_threshold  = soos_pkg::RST_HOLD_THRESHOLD;
         cfg.attack_gap      = soos_pkg::RST_ATTACK_GAP;
         cfg.quiet_limit     = soos_pkg::RST_QUIET_LIMIT;
         cfg.shortest_sound  = soos_pkg::RST_SHORTEST_SOUND;
         cfg.segment_size    = soos_pkg::RST_SEGMENT_SIZE;
         clear_tracking();
         expected_sounds.delete();
      end else begin
         // Results are checked before this edge's sample is modeled; a result
         // can never leave on the edge its sample enters.
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tlast, rsp_tdata};
            if (expected_sounds.size() == 0) begin
               flag_mismatch("result with nothing expected", "none", describe(seen));
            end else begin
               want = expected_sounds.pop_front();
               if (seen.begin_index !== want.begin_index ||
                   seen.end_index !== want.end_index ||
                   seen.begin_segment !== want.begin_segment ||
                   seen.end_segment !== want.end_segment ||
                   seen.sound_number !== want.sound_number ||
                   seen.final_of_run !== want.final_of_run) begin
                  flag_mismatch("wrong result", describe(want), describe(seen));
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               soos_pkg::CSR_START_THRESHOLD: cfg.start_threshold = csr_wdata;
               soos_pkg::CSR_HOLD_THRESHOLD:  cfg.hold_threshold = csr_wdata;
               soos_pkg::CSR_ATTACK_GAP:      cfg.attack_gap = csr_wdata;
               soos_pkg::CSR_QUIET_LIMIT:     cfg.quiet_limit = csr_wdata;
               soos_pkg::CSR_SHORTEST_SOUND:  cfg.shortest_sound = csr_wdata;
               soos_pkg::CSR_SEGMENT_SIZE:    cfg.segment_size = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            segment_sample(req_tdata, req_tlast);
         end
      end
      mismatch_count <= mismatches;
      pending_sounds <= expected_sounds.size();
   end

endmodule

// ===== bench/sound_onset_offset_segmenter_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sound onset/offset segmenter testbench
// Drives short directed recordings that hit the threshold and segment corner
// cases, then random recordings under many register settings, with random
// gaps on the sample side and random stalls on the result side. The checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module sound_onset_offset_segmenter_tb;

   localparam int CYCLE_LIMIT  = 250000;
   localparam int DRAIN_CYCLES = 12;
   localparam int RANDOM_ITEMS = 550;

   // Indexes past the register list; writes there must change nothing.
   localparam logic [soos_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [soos_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                  req_tvalid = 1'b0;
   logic                                  req_tready;
   logic [soos_pkg::SAMPLE_BITS-1:0]      req_tdata = '0;
   logic                                  req_tlast = 1'b0;
   logic                                  rsp_tvalid;
   logic                                  rsp_tready = 1'b0;
   logic [soos_pkg::RSP_DATA_BITS-1:0]    rsp_tdata;
   logic                                  rsp_tlast;
   logic                                  csr_we = 1'b0;
   logic [soos_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [soos_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;

   int mismatch_count;
   int pending_sounds;
   int cycle_count = 0;

   // Sender state and the settings that shape the random samples.
   int items_accepted = 0;
   int burst_left = 0;
   int cur_start = 16384;
   int cur_cont = 1024;
   int cur_seg = 1024;

   // Receiver stall pattern.
   int ready_mode = 0;
   int ready_left = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sound_onset_offset_segmenter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   segmenter_checker i_sound_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_sounds (pending_sounds)
   );

   // The receiver switches between always ready, coin-flip ready and long stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_mode <= 0;
         ready_left <= 0;
      end else begin
         if (ready_left == 0) begin
            ready_mode <= $urandom_range(0, 2);
            ready_left <= $urandom_range(20, 200);
         end else begin
            ready_left <= ready_left - 1;
         end
         case (ready_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 1) == 1);
            default: rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic write_reg(input logic [soos_pkg::CSR_INDEX_BITS-1:0] idx,
                            input int unsigned value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[15:0];
      @(posedge clock);
   endtask

   task automatic apply_config(input int unsigned start_thr, input int unsigned cont_thr,
                               input int unsigned attack, input int unsigned quiet,
                               input int unsigned min_len, input int unsigned seg_size);
      write_reg(soos_pkg::CSR_START_THRESHOLD, start_thr);
      write_reg(soos_pkg::CSR_HOLD_THRESHOLD, cont_thr);
      write_reg(soos_pkg::CSR_ATTACK_GAP, attack);
      write_reg(soos_pkg::CSR_QUIET_LIMIT, quiet);
      write_reg(soos_pkg::CSR_SHORTEST_SOUND, min_len);
      write_reg(soos_pkg::CSR_SEGMENT_SIZE, seg_size);
      csr_we <= 1'b0;
      cur_start = start_thr;
      cur_cont = cont_thr;
      cur_seg = (seg_size == 0) ? 1 : seg_size;
   endtask

   // Items go out in bursts; tvalid drops only when a real gap follows.
   task automatic send_sample(input logic [15:0] sample, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 10);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= sample;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      items_accepted++;
   endtask

   // The pending count is registered, so it is first read in the cycle after the last item.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_sounds != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Random sample whose magnitude lies in [lo, hi], with a random sign.
   function automatic logic [15:0] pick_sample(input int lo, input int hi);
      int unsigned level;
      logic [15:0] value;
      if (lo < 0) lo = 0;
      if (hi > 32768) hi = 32768;
      if (hi < lo) hi = lo;
      level = $urandom_range(hi, lo);
      value = level[15:0];
      if ($urandom_range(0, 1) == 1) begin
         value = -value;
      end
      return value;
   endfunction

   // A recording made of runs: sound onsets, quiet stretches, mid-level
   // stretches and the odd burst of noise.
   task automatic play_recording(input int len, input bit close_it);
      int run_left;
      int run_kind;
      bit run_first;
      logic [15:0] sample;
      run_left = 0;
      run_kind = 0;
      run_first = 1'b0;
      for (int k = 0; k < len; k++) begin
         if (run_left == 0) begin
            run_kind = $urandom_range(0, 9);
            run_left = $urandom_range(1, 8);
            run_first = 1'b1;
         end
         if (run_kind <= 3) begin
            sample = run_first ? pick_sample(cur_start, 32768) : pick_sample(cur_cont, 32768);
         end else if (run_kind <= 6) begin
            sample = pick_sample(0, cur_cont - 1);
         end else if (run_kind <= 8) begin
            sample = pick_sample(cur_cont, cur_start - 1);
         end else begin
            sample = 16'($urandom_range(0, 65535));
         end
         run_first = 1'b0;
         run_left--;
         send_sample(sample, close_it && (k == len - 1));
      end
   endtask

   initial begin
      int random_goal;
      int phase_end;
      int pick;
      int unsigned start_thr;
      int unsigned cont_thr;
      int unsigned attack;
      int unsigned quiet;
      int unsigned min_len;
      int unsigned seg_size;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: everything falls into the long lead-in.
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h0000, 1'b1);
      wait_idle();

      write_reg(CSR_SPARE_LO, $urandom_range(0, 65535));
      write_reg(CSR_SPARE_HI, $urandom_range(0, 65535));
      apply_config(16384, 1024, 0, 0, 0, 1);
      // Restart on a new onset, close after quiet, and two closes on the last item.
      send_sample(16'h0000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h0000, 1'b0);
      send_sample(16'd2000, 1'b0);
      send_sample(16'hC000, 1'b0);
      send_sample(16'hB1E0, 1'b1);
      wait_idle();

      // Top thresholds, zero segment size and a sound that is too short to emit.
      apply_config(32768, 32768, 0, 3, 2, 0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b0);
      send_sample(16'h1234, 1'b0);
      send_sample(16'hFFFF, 1'b0);
      send_sample(16'h0001, 1'b0);
      send_sample(16'h8000, 1'b1);
      wait_idle();

      // The segment size shrinks below the current offset mid-recording.
      apply_config(0, 0, 0, 0, 65535, 8);
      repeat (4) send_sample(16'($urandom_range(0, 65535)), 1'b0);
      wait_idle();
      write_reg(soos_pkg::CSR_SEGMENT_SIZE, 2);
      csr_we <= 1'b0;
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      wait_idle();

      apply_config(0, 0, 65535, 65535, 65535, 65535);
      send_sample(16'h8000, 1'b0);
      send_sample(16'h7FFF, 1'b1);
      wait_idle();

      random_goal = items_accepted + RANDOM_ITEMS;
      while (items_accepted < random_goal) begin
         pick = $urandom_range(0, 9);
         start_thr = (pick < 2) ? 0 : (pick < 4) ? 32768 : $urandom_range(1000, 32767);
         pick = $urandom_range(0, 9);
         cont_thr = (pick < 2) ? 0 : (pick < 3) ? 32768 : $urandom_range(0, start_thr);
         attack = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 12);
         quiet = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 6);
         min_len = ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 10);
         pick = $urandom_range(0, 9);
         seg_size = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 6);
         apply_config(start_thr, cont_thr, attack, quiet, min_len, seg_size);

         phase_end = items_accepted + $urandom_range(50, 90);
         while (items_accepted < phase_end) begin
            if ($urandom_range(0, 9) == 0) begin
               repeat ($urandom_range(3, 20)) begin
                  send_sample(16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0);
               end
            end else begin
               play_recording(cur_seg + $urandom_range(4, 40), $urandom_range(0, 4) != 0);
            end
         end
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
